// ===== sv/hmu_pkg.sv =====
// hmu_pkg: shared types, codes and defaults of the handoff mutex unit
package hmu_pkg;

   localparam int unsigned MAX_REQUESTERS_DEF = 16;
   localparam int unsigned COUNT_BITS_DEF     = 16;
   localparam int unsigned QUEUE_DEPTH        = 2;
   localparam int unsigned ID_BITS            = 4;

   typedef enum logic [1:0] {
      OP_LOCK    = 2'd0,
      OP_TRYLOCK = 2'd1,
      OP_UNLOCK  = 2'd2,
      OP_DESTROY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_BUSY      = 3'd2,
      ST_DEADLOCK  = 3'd3,
      ST_NOT_OWNER = 3'd4,
      ST_LIMIT     = 3'd5
   } status_type;

   localparam logic [1:0] MODE_NORMAL     = 2'd0;
   localparam logic [1:0] MODE_RECURSIVE  = 2'd1;
   localparam logic [1:0] MODE_ERRORCHECK = 2'd2;

   typedef struct packed {
      op_type              operation;
      logic [ID_BITS-1:0]  requester_id;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic                wake_valid;
      logic [ID_BITS-1:0]  wake_id;
      logic                held;
      logic [ID_BITS-1:0]  owner_now;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic                acquire;
      logic [ID_BITS-1:0]  id;
   } cmd_type;

endpackage

// ===== sv/fifo_handoff_mutex_unit.sv =====
// fifo_handoff_mutex_unit: top level of the hardware lock with a waiter queue
//
//   channel   ports                           moves
//   request   req_push  req_full  req_data    operation, requester_id
//   response  rsp_pop   rsp_empty rsp_data    status, wake, held, owner
//   csr       csr_valid csr_ready csr_data    mutex_mode
//
// one request per cycle unless a handoff unlock waits or a full queue stalls it
// a handoff unlock waits when the queue head just moved or was just written,
// caused by the registered read port of the waiter memory
// reset is synchronous and needs no clearing pass; csr_ready is always high
// each side stalls on its own through the two-entry command and response queues
module fifo_handoff_mutex_unit #(
   parameter int unsigned MAX_REQUESTERS = hmu_pkg::MAX_REQUESTERS_DEF,
   parameter int unsigned COUNT_BITS     = hmu_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  hmu_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   output hmu_pkg::rsp_type rsp_data,
   input  logic             rsp_pop,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

   logic             cmd_valid, cmd_pop, rsp_push, rsp_full;
   hmu_pkg::cmd_type cmd;
   hmu_pkg::rsp_type rsp_new;

   assign csr_ready = 1'b1;

   hmu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   hmu_back #(
      .MAX_REQUESTERS (MAX_REQUESTERS),
      .COUNT_BITS     (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   hmu_queue #(
      .item_type (hmu_pkg::rsp_type),
      .DEPTH     (hmu_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

// ===== sv/hmu_queue.sv =====
// hmu_queue: small synchronous queue of generic items
module hmu_queue #(
   parameter type         item_type = logic,
   parameter int unsigned DEPTH     = hmu_pkg::QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   item_type              slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_BITS'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_BITS'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

// ===== sv/hmu_front.sv =====
// hmu_front: request intake, classification and command queue
module hmu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  hmu_pkg::req_type req_data,
   output logic             req_full,
   output logic             cmd_valid,
   output hmu_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   hmu_pkg::cmd_type cmd_new;
   logic             cmd_empty;

   always_comb begin
      cmd_new.op      = req_data.operation;
      cmd_new.id      = req_data.requester_id;
      cmd_new.acquire = (req_data.operation == hmu_pkg::OP_LOCK) ||
                        (req_data.operation == hmu_pkg::OP_TRYLOCK);
   end

   hmu_queue #(
      .item_type (hmu_pkg::cmd_type),
      .DEPTH     (hmu_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_new),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

// ===== sv/hmu_back.sv =====
// hmu_back: lock state, hold count and waiter queue, one command per step
module hmu_back #(
   parameter int unsigned MAX_REQUESTERS = hmu_pkg::MAX_REQUESTERS_DEF,
   parameter int unsigned COUNT_BITS     = hmu_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [1:0]       csr_data,
   input  logic             cmd_valid,
   input  hmu_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output hmu_pkg::rsp_type rsp
);

   localparam int unsigned PTR_BITS  = $clog2(MAX_REQUESTERS);
   localparam int unsigned FILL_BITS = $clog2(MAX_REQUESTERS + 1);
   localparam int unsigned IDW       = hmu_pkg::ID_BITS;

   logic [1:0]            mode_ff;
   logic                  owner_valid_ff, owner_valid_in;
   logic [IDW-1:0]        owner_id_ff, owner_id_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic                  fresh_ff, fresh_in;
   logic [IDW-1:0]        waiter_ff [MAX_REQUESTERS];
   logic [IDW-1:0]        head_id_ff;

   logic                  is_owner, mode_rec, mode_err, count_max, count_multi;
   logic                  fifo_full, fifo_empty, needs_head, issue;
   logic                  wr_en, handoff;
   hmu_pkg::status_type   status;

   assign is_owner    = owner_valid_ff && (owner_id_ff == cmd.id);
   assign mode_rec    = (mode_ff == hmu_pkg::MODE_RECURSIVE);
   assign mode_err    = (mode_ff == hmu_pkg::MODE_ERRORCHECK);
   assign count_max   = (count_ff == '1);
   assign count_multi = (count_ff > COUNT_BITS'(1));
   assign fifo_full   = (fill_ff == FILL_BITS'(MAX_REQUESTERS));
   assign fifo_empty  = (fill_ff == '0);
   assign needs_head  = (cmd.op == hmu_pkg::OP_UNLOCK) && is_owner &&
                        !(mode_rec && count_multi) && !fifo_empty;
   assign issue       = cmd_valid && !rsp_full && (!needs_head || fresh_ff);
   assign cmd_pop     = issue;
   assign rsp_push    = issue;

   always_comb begin
      owner_valid_in = owner_valid_ff;
      owner_id_in    = owner_id_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      status         = hmu_pkg::ST_OK;
      wr_en          = 1'b0;
      handoff        = 1'b0;
      if (cmd.acquire) begin
         priority if (!owner_valid_ff) begin
            owner_valid_in = 1'b1;
            owner_id_in    = cmd.id;
            count_in       = COUNT_BITS'(1);
         end else if (is_owner && mode_rec) begin
            if (count_max) begin
               status = hmu_pkg::ST_LIMIT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else if (cmd.op == hmu_pkg::OP_TRYLOCK) begin
            status = hmu_pkg::ST_BUSY;
         end else if (is_owner && mode_err) begin
            status = hmu_pkg::ST_DEADLOCK;
         end else if (fifo_full) begin
            status = hmu_pkg::ST_LIMIT;
         end else begin
            status  = hmu_pkg::ST_QUEUED;
            wr_en   = 1'b1;
            tail_in = (tail_ff == PTR_BITS'(MAX_REQUESTERS - 1)) ? '0 : tail_ff + 1'b1;
            fill_in = fill_ff + 1'b1;
         end
      end else if (cmd.op == hmu_pkg::OP_UNLOCK) begin
         priority if (!is_owner) begin
            status = hmu_pkg::ST_NOT_OWNER;
         end else if (mode_rec && count_multi) begin
            count_in = count_ff - 1'b1;
         end else if (fifo_empty) begin
            owner_valid_in = 1'b0;
            owner_id_in    = '0;
            count_in       = '0;
         end else begin
            handoff        = 1'b1;
            owner_valid_in = 1'b1;
            owner_id_in    = head_id_ff;
            count_in       = COUNT_BITS'(1);
            head_in = (head_ff == PTR_BITS'(MAX_REQUESTERS - 1)) ? '0 : head_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
         end
      end else begin
         status = owner_valid_ff ? hmu_pkg::ST_BUSY : hmu_pkg::ST_OK;
      end

      rsp.status     = status;
      rsp.wake_valid = handoff;
      rsp.wake_id    = handoff ? head_id_ff : '0;
      rsp.held       = owner_valid_in;
      rsp.owner_now  = owner_valid_in ? owner_id_in : '0;

      // head entry read is registered: stale after the head moves or is written
      fresh_in = 1'b1;
      if (issue) begin
         fresh_in = !handoff && !(wr_en && (tail_ff == head_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= hmu_pkg::MODE_NORMAL;
         owner_valid_ff <= 1'b0;
         owner_id_ff    <= '0;
         count_ff       <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         fresh_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_data;
         end
         fresh_ff <= fresh_in;
         if (issue) begin
            owner_valid_ff <= owner_valid_in;
            owner_id_ff    <= owner_id_in;
            count_ff       <= count_in;
            head_ff        <= head_in;
            tail_ff        <= tail_in;
            fill_ff        <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue && wr_en) begin
         waiter_ff[tail_ff] <= cmd.id;
      end
      head_id_ff <= waiter_ff[head_ff];
   end

endmodule

// ===== sv/hmu_checker.sv =====
// hmu_checker: port-level assertions for the handoff mutex unit, bound to the top
module hmu_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input hmu_pkg::rsp_type rsp_data,
   input logic             rsp_pop
);

   // a handoff always leaves the woken requester as owner
   a_wake_owner: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.wake_valid |->
         rsp_data.held && rsp_data.owner_now == rsp_data.wake_id &&
         rsp_data.status == hmu_pkg::ST_OK)
      else $error("handoff without matching owner");

   // a free lock reports no owner
   a_free_owner: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.held |-> rsp_data.owner_now == '0 && !rsp_data.wake_valid)
      else $error("free lock shows an owner");

   // responses with any status other than OK never wake anyone
   a_refused_no_wake: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status != hmu_pkg::ST_OK |->
         !rsp_data.wake_valid && rsp_data.wake_id == '0)
      else $error("wake on a refused request");

   // a waiting response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("response changed while waiting");

endmodule

bind fifo_handoff_mutex_unit hmu_checker u_hmu_checker (.*);
